### rtl/greedy_min_distance_point_thinning_top_assert.svh
// Assertion macros shared by the thinning block.
`ifndef GREEDY_MIN_DISTANCE_POINT_THINNING_TOP_ASSERT_SVH
`define GREEDY_MIN_DISTANCE_POINT_THINNING_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define GMDPT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GMDPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define GMDPT_ASSERT(lbl, clk, rst_n, prop, msg)
`define GMDPT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/gmdpt_pkg.sv
`timescale 1ns / 1ps

package gmdpt_pkg;

    localparam int IDX_W       = 16;
    localparam int DIST_W      = 16;
    localparam int LIMIT_W     = 2 * DIST_W;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Register index is taken from the word address bit of paddr.
    localparam logic REG_MIN_DISTANCE = 1'b0;

    localparam logic [DIST_W-1:0] MIN_DISTANCE_RESET = 16'd1;

    typedef struct packed {
        logic busy;
        logic close;
    } dist_status_t;

    typedef struct packed {
        logic valid;
        logic flush;
    } dist_ctrl_t;

endpackage

### rtl/gmdpt_store.sv
`timescale 1ns / 1ps

module gmdpt_store #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 48
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/gmdpt_dist.sv
`timescale 1ns / 1ps

module gmdpt_dist #(
    parameter int COORD_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gmdpt_pkg::dist_ctrl_t            ctl,
    input  logic signed [COORD_BITS-1:0]     pt_x,
    input  logic signed [COORD_BITS-1:0]     pt_y,
    input  logic signed [COORD_BITS-1:0]     pt_z,
    input  logic signed [COORD_BITS-1:0]     kept_x,
    input  logic signed [COORD_BITS-1:0]     kept_y,
    input  logic signed [COORD_BITS-1:0]     kept_z,
    input  logic [gmdpt_pkg::LIMIT_W-1:0]    limit,
    output gmdpt_pkg::dist_status_t          status
);
    import gmdpt_pkg::*;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SQ_W   = 2 * DIFF_W;
    localparam int SUM_W  = SQ_W + 2;
    localparam int CMP_W  = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [SQ_W-1:0]   sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic                     v1_reg, v2_reg, v3_reg, close_reg;
    logic signed [SQ_W-1:0]   sqx_next, sqy_next, sqz_next;
    logic [SUM_W-1:0]         sum_next;
    logic                     close_next;

    assign sqx_next = dx_reg * dx_reg;
    assign sqy_next = dy_reg * dy_reg;
    assign sqz_next = dz_reg * dz_reg;

    // Squares are never negative, so their bit patterns add as unsigned values.
    assign sum_next = SUM_W'($unsigned(sqx_reg)) + SUM_W'($unsigned(sqy_reg))
                    + SUM_W'($unsigned(sqz_reg));

    assign close_next = v3_reg && (CMP_W'(sum_reg) < CMP_W'(limit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            close_reg <= 1'b0;
        end
        else if (ctl.flush)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            close_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= ctl.valid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            close_reg <= close_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= DIFF_W'(pt_x) - DIFF_W'(kept_x);
        dy_reg  <= DIFF_W'(pt_y) - DIFF_W'(kept_y);
        dz_reg  <= DIFF_W'(pt_z) - DIFF_W'(kept_z);
        sqx_reg <= sqx_next;
        sqy_reg <= sqy_next;
        sqz_reg <= sqz_next;
        sum_reg <= sum_next;
    end

    assign status.busy  = v1_reg | v2_reg | v3_reg;
    assign status.close = close_reg;

endmodule

### rtl/gmdpt_ctrl.sv
`timescale 1ns / 1ps
`include "greedy_min_distance_point_thinning_top_assert.svh"

module gmdpt_ctrl #(
    parameter int MAX_KEPT   = 1024,
    parameter int COORD_BITS = 16,
    parameter int ADDR_W     = 10,
    parameter int CNT_W      = 11
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [gmdpt_pkg::IDX_W-1:0]        in_index,
    input  logic signed [COORD_BITS-1:0]       in_x,
    input  logic signed [COORD_BITS-1:0]       in_y,
    input  logic signed [COORD_BITS-1:0]       in_z,
    input  logic                               first,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [gmdpt_pkg::IDX_W-1:0]        sel_index,
    output logic signed [COORD_BITS-1:0]       sel_x,
    output logic signed [COORD_BITS-1:0]       sel_y,
    output logic signed [COORD_BITS-1:0]       sel_z,
    output logic                               store_overflow,
    output logic                               wr_en,
    output logic [ADDR_W-1:0]                  wr_addr,
    output logic [3*COORD_BITS-1:0]            wr_data,
    output logic                               rd_en,
    output logic [ADDR_W-1:0]                  rd_addr,
    output logic signed [COORD_BITS-1:0]       pt_x,
    output logic signed [COORD_BITS-1:0]       pt_y,
    output logic signed [COORD_BITS-1:0]       pt_z,
    output gmdpt_pkg::dist_ctrl_t              dist_ctl,
    input  gmdpt_pkg::dist_status_t            dist_status
);
    import gmdpt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic                    rd_valid_reg, rd_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]        pt_index_reg;
    logic signed [COORD_BITS-1:0] pt_x_reg, pt_y_reg, pt_z_reg;
    logic [IDX_W-1:0]        sel_index_reg;
    logic signed [COORD_BITS-1:0] sel_x_reg, sel_y_reg, sel_z_reg;
    logic                    ovf_reg;
    logic                    accept, rd_issue, reject, scan_done, full, load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg >= CNT_W'(MAX_KEPT));
    assign rd_issue  = (state_reg == ST_SCAN) && (rd_ptr_reg < count_reg);
    assign reject    = (state_reg == ST_SCAN) && dist_status.close;
    // The scan is over once every stored entry has left the distance pipeline unrejected.
    assign scan_done = (state_reg == ST_SCAN) && !rd_issue && !rd_valid_reg
                       && !dist_status.busy && !dist_status.close;
    assign load      = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        rd_valid_next  = rd_issue && !reject;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_SCAN;
                    rd_ptr_next = '0;
                    if (first)
                    begin
                        count_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                if (reject)
                begin
                    state_next = ST_IDLE;
                end
                else if (scan_done)
                begin
                    state_next = ST_DONE;
                end
                else if (rd_issue)
                begin
                    rd_ptr_next = rd_ptr_reg + CNT_W'(1);
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (!full)
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rd_ptr_reg    <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pt_index_reg <= in_index;
            pt_x_reg     <= in_x;
            pt_y_reg     <= in_y;
            pt_z_reg     <= in_z;
        end
        if (load)
        begin
            sel_index_reg <= pt_index_reg;
            sel_x_reg     <= pt_x_reg;
            sel_y_reg     <= pt_y_reg;
            sel_z_reg     <= pt_z_reg;
            ovf_reg       <= full;
        end
    end

    assign wr_en   = load && !full;
    assign wr_addr = count_reg[ADDR_W-1:0];
    assign wr_data = {pt_x_reg, pt_y_reg, pt_z_reg};
    assign rd_en   = rd_issue;
    assign rd_addr = rd_ptr_reg[ADDR_W-1:0];

    assign pt_x = pt_x_reg;
    assign pt_y = pt_y_reg;
    assign pt_z = pt_z_reg;

    assign dist_ctl.valid = rd_valid_reg;
    assign dist_ctl.flush = reject;

    assign out_valid      = out_valid_reg;
    assign sel_index      = sel_index_reg;
    assign sel_x          = sel_x_reg;
    assign sel_y          = sel_y_reg;
    assign sel_z          = sel_z_reg;
    assign store_overflow = ovf_reg;

    `GMDPT_ASSERT(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_KEPT), "store count beyond depth")
    `GMDPT_ASSERT_IMPL(a_write_ok, clk, rst_n, wr_en, (state_reg == ST_DONE) && (count_reg < CNT_W'(MAX_KEPT)), "store write outside result load or into full store")
    `GMDPT_ASSERT_IMPL(a_read_below_count, clk, rst_n, rd_en, rd_ptr_reg < count_reg, "read of an unfilled store entry")
    `GMDPT_ASSERT_IMPL(a_close_in_scan, clk, rst_n, dist_status.close, state_reg == ST_SCAN, "distance hit outside a scan")
    `GMDPT_ASSERT_IMPL(a_reject_no_result, clk, rst_n, reject, ##1 (state_reg == ST_IDLE) && $stable(count_reg), "rejected point changed the store")

endmodule

### rtl/greedy_min_distance_point_thinning_top.sv
`timescale 1ns / 1ps
// A point is compared with each stored point, one store read a cycle, through a
// four-stage distance pipeline; a selected point appears at the output after the scan of all
// kept points, a rejected one ends the scan sooner. A new point is taken only after the last
// one is selected or rejected, as in_ready is high only while the control is idle.
// Reset: rst_n clears the store count, control state and sets min_distance to 1; the store
// itself needs no clearing.

module greedy_min_distance_point_thinning_top #(
    parameter int MAX_KEPT   = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [gmdpt_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [gmdpt_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gmdpt_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                 pready,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [gmdpt_pkg::IDX_W-1:0]          in_index,
    input  logic signed [COORD_BITS-1:0]         in_x,
    input  logic signed [COORD_BITS-1:0]         in_y,
    input  logic signed [COORD_BITS-1:0]         in_z,
    input  logic                                 first,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gmdpt_pkg::IDX_W-1:0]          sel_index,
    output logic signed [COORD_BITS-1:0]         sel_x,
    output logic signed [COORD_BITS-1:0]         sel_y,
    output logic signed [COORD_BITS-1:0]         sel_z,
    output logic                                 store_overflow
);
    import gmdpt_pkg::*;

    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int DATA_W = 3 * COORD_BITS;

    logic [DIST_W-1:0]  min_distance_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               cfg_wr, reg_sel;

    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [DATA_W-1:0]  wr_data, rd_data;
    logic signed [COORD_BITS-1:0] pt_x, pt_y, pt_z;
    dist_ctrl_t         dist_ctl;
    dist_status_t       dist_status;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_MIN_DISTANCE);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;
    assign prdata  = reg_sel ? APB_DATA_W'(min_distance_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_distance_reg <= MIN_DISTANCE_RESET;
            limit_reg        <= LIMIT_W'(MIN_DISTANCE_RESET);
        end
        else
        begin
            if (cfg_wr)
            begin
                min_distance_reg <= pwdata[DIST_W-1:0];
            end
            // Squared spacing is registered from the register and follows it in the next cycle.
            limit_reg <= min_distance_reg * min_distance_reg;
        end
    end

    gmdpt_store #(
        .DEPTH  (MAX_KEPT),
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gmdpt_dist #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (dist_ctl),
        .pt_x   (pt_x),
        .pt_y   (pt_y),
        .pt_z   (pt_z),
        .kept_x (rd_data[3*COORD_BITS-1:2*COORD_BITS]),
        .kept_y (rd_data[2*COORD_BITS-1:COORD_BITS]),
        .kept_z (rd_data[COORD_BITS-1:0]),
        .limit  (limit_reg),
        .status (dist_status)
    );

    gmdpt_ctrl #(
        .MAX_KEPT   (MAX_KEPT),
        .COORD_BITS (COORD_BITS),
        .ADDR_W     (ADDR_W),
        .CNT_W      (CNT_W)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_index       (in_index),
        .in_x           (in_x),
        .in_y           (in_y),
        .in_z           (in_z),
        .first          (first),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sel_index      (sel_index),
        .sel_x          (sel_x),
        .sel_y          (sel_y),
        .sel_z          (sel_z),
        .store_overflow (store_overflow),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .pt_x           (pt_x),
        .pt_y           (pt_y),
        .pt_z           (pt_z),
        .dist_ctl       (dist_ctl),
        .dist_status    (dist_status)
    );

endmodule
